[rtl/wcws_pkg.sv]
// Package for the word clock word select block: word bits, dialect and step codes, helpers.
`default_nettype none

package wcws_pkg;

  // Field widths
  localparam int HoursW   = 5;
  localparam int MinutesW = 6;
  localparam int MaskW    = 24;
  localparam int DialectW = 2;
  localparam int HourIdxW = 4;

  // Panel word bit positions
  localparam int BitEs       = 0;
  localparam int BitIst      = 1;
  localparam int BitVor      = 2;
  localparam int BitNach     = 3;
  localparam int BitUhr      = 4;
  localparam int BitMFuenf   = 5;
  localparam int BitMZehn    = 6;
  localparam int BitViertel  = 7;
  localparam int BitZwanzig  = 8;
  localparam int BitHalb     = 9;
  localparam int BitDviertel = 10;
  localparam int BitEinShort = 11;
  localparam int BitEins     = 12;
  localparam int BitZwoelf   = 23;

  typedef logic [MaskW-1:0]    mask_t;
  typedef logic [HourIdxW-1:0] hour_idx_t;

  typedef enum logic [DialectW-1:0] {
    DIA_STANDARD = 2'd0,
    DIA_SWABIAN  = 2'd1,
    DIA_BAVARIAN = 2'd2,
    DIA_SAXON    = 2'd3
  } dialect_t;

  // Five-minute steps of the hour
  typedef enum logic [3:0] {
    STEP_FULL         = 4'd0,
    STEP_FIVE_PAST    = 4'd1,
    STEP_TEN_PAST     = 4'd2,
    STEP_QUARTER_PAST = 4'd3,
    STEP_TWENTY_PAST  = 4'd4,
    STEP_FIVE_TO_HALF = 4'd5,
    STEP_HALF         = 4'd6,
    STEP_FIVE_PAST_HF = 4'd7,
    STEP_TWENTY_TO    = 4'd8,
    STEP_QUARTER_TO   = 4'd9,
    STEP_TEN_TO       = 4'd10,
    STEP_FIVE_TO      = 4'd11
  } step_t;

  // Map a minute value to its five-minute step; 55 and above saturate to five-to
  function automatic step_t minute_step(logic [MinutesW-1:0] m);
    step_t s;
    s = STEP_FULL;
    if (m >= 6'd5)  s = STEP_FIVE_PAST;
    if (m >= 6'd10) s = STEP_TEN_PAST;
    if (m >= 6'd15) s = STEP_QUARTER_PAST;
    if (m >= 6'd20) s = STEP_TWENTY_PAST;
    if (m >= 6'd25) s = STEP_FIVE_TO_HALF;
    if (m >= 6'd30) s = STEP_HALF;
    if (m >= 6'd35) s = STEP_FIVE_PAST_HF;
    if (m >= 6'd40) s = STEP_TWENTY_TO;
    if (m >= 6'd45) s = STEP_QUARTER_TO;
    if (m >= 6'd50) s = STEP_TEN_TO;
    if (m >= 6'd55) s = STEP_FIVE_TO;
    return s;
  endfunction

  // Reduce a 5-bit hour modulo 12
  function automatic hour_idx_t hour_mod12(logic [HoursW-1:0] h);
    logic [HoursW-1:0] r;
    r = h;
    if (h >= 5'd24) begin
      r = h - 5'd24;
    end else if (h >= 5'd12) begin
      r = h - 5'd12;
    end
    return r[HourIdxW-1:0];
  endfunction

  // Following hour index, wrapping eleven back to zero
  function automatic hour_idx_t hour_next(hour_idx_t idx);
    hour_idx_t r;
    r = (idx == 4'd11) ? 4'd0 : idx + 4'd1;
    return r;
  endfunction

  // Hour word bits; full hour adds UHR and uses the short EIN for one
  function automatic mask_t hour_word(hour_idx_t idx, logic full);
    mask_t m;
    m = '0;
    if (full) m[BitUhr] = 1'b1;
    if (full && idx == 4'd1) begin
      m[BitEinShort] = 1'b1;
    end else if (idx == 4'd0) begin
      m[BitZwoelf] = 1'b1;
    end else begin
      m[BitEins + int'(idx) - 1] = 1'b1;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/wcws_if.sv]
// Valid/ready channel interfaces for time requests and word mask results.
`default_nettype none

interface wcws_time_if
  import wcws_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [HoursW-1:0]   hours;
  logic [MinutesW-1:0] minutes;

  modport source (output valid, output hours, output minutes, input ready);
  modport sink   (input valid, input hours, input minutes, output ready);
endinterface

interface wcws_mask_if
  import wcws_pkg::*;
;
  logic  valid;
  logic  ready;
  mask_t word_mask;

  modport source (output valid, output word_mask, input ready);
  modport sink   (input valid, input word_mask, output ready);
endinterface

`default_nettype wire

[rtl/wcws_decode.sv]
// Combinational decode of a registered time of day into the panel word mask.
`default_nettype none

module wcws_decode
  import wcws_pkg::*;
(
  input  wire logic [HoursW-1:0]   hours,
  input  wire logic [MinutesW-1:0] minutes,
  input  wire dialect_t            dialect,
  output mask_t                    word_mask
);

  step_t     step;
  hour_idx_t cur_idx;
  hour_idx_t nxt_idx;
  mask_t     cur_word;
  mask_t     nxt_word;

  // Split the time into step and hour words
  always_comb begin
    step     = minute_step(minutes);
    cur_idx  = hour_mod12(hours);
    nxt_idx  = hour_next(cur_idx);
    cur_word = hour_word(cur_idx, 1'b0);
    nxt_word = hour_word(nxt_idx, 1'b0);
  end

  // Build the phrase for the step under the configured dialect
  always_comb begin
    mask_t m;
    m = '0;
    m[BitEs]  = 1'b1;
    m[BitIst] = 1'b1;
    unique case (step)
      STEP_FULL: begin
        m = m | hour_word(cur_idx, 1'b1);
      end
      STEP_FIVE_PAST: begin
        m[BitMFuenf] = 1'b1;
        m[BitNach]   = 1'b1;
        m = m | cur_word;
      end
      STEP_TEN_PAST: begin
        m[BitMZehn] = 1'b1;
        m[BitNach]  = 1'b1;
        m = m | cur_word;
      end
      STEP_QUARTER_PAST: begin
        m[BitViertel] = 1'b1;
        if (dialect == DIA_SWABIAN || dialect == DIA_SAXON) begin
          m = m | nxt_word;
        end else begin
          m[BitNach] = 1'b1;
          m = m | cur_word;
        end
      end
      STEP_TWENTY_PAST: begin
        if (dialect == DIA_SAXON) begin
          m[BitMZehn] = 1'b1;
          m[BitVor]   = 1'b1;
          m[BitHalb]  = 1'b1;
          m = m | nxt_word;
        end else begin
          m[BitZwanzig] = 1'b1;
          m[BitNach]    = 1'b1;
          m = m | cur_word;
        end
      end
      STEP_FIVE_TO_HALF: begin
        m[BitMFuenf] = 1'b1;
        m[BitVor]    = 1'b1;
        m[BitHalb]   = 1'b1;
        m = m | nxt_word;
      end
      STEP_HALF: begin
        m[BitHalb] = 1'b1;
        m = m | nxt_word;
      end
      STEP_FIVE_PAST_HF: begin
        m[BitMFuenf] = 1'b1;
        m[BitNach]   = 1'b1;
        m[BitHalb]   = 1'b1;
        m = m | nxt_word;
      end
      STEP_TWENTY_TO: begin
        if (dialect == DIA_SAXON) begin
          m[BitMZehn] = 1'b1;
          m[BitNach]  = 1'b1;
          m[BitHalb]  = 1'b1;
        end else begin
          m[BitZwanzig] = 1'b1;
          m[BitVor]     = 1'b1;
        end
        m = m | nxt_word;
      end
      STEP_QUARTER_TO: begin
        if (dialect == DIA_STANDARD) begin
          m[BitViertel] = 1'b1;
          m[BitVor]     = 1'b1;
        end else begin
          m[BitDviertel] = 1'b1;
        end
        m = m | nxt_word;
      end
      STEP_TEN_TO: begin
        m[BitMZehn] = 1'b1;
        m[BitVor]   = 1'b1;
        m = m | nxt_word;
      end
      default: begin
        m[BitMFuenf] = 1'b1;
        m[BitVor]    = 1'b1;
        m = m | nxt_word;
      end
    endcase
    word_mask = m;
  end

endmodule

`default_nettype wire

[rtl/german_word_clock_word_select_top.sv]
// Top level: input register, word decode and result register with valid/ready flow control.
// An accepted time request goes through the input register and then the result register.
// Throughput: one request per cycle; the input register refills while the result register
// drains, so requests stream back to back unless the result side stalls.
// Reset: synchronous active-high rst clears both valid flags and sets dialect to standard.
// The dialect register is sampled by the decode stage of each request.
`default_nettype none

module german_word_clock_word_select_top
  import wcws_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_wen,
  input  wire logic [DialectW-1:0] cfg_wdata,
  wcws_time_if.sink                time_in,
  wcws_mask_if.source              mask_out
);

  dialect_t            dialect;
  logic                s1_valid;
  logic [HoursW-1:0]   s1_hours;
  logic [MinutesW-1:0] s1_minutes;
  logic                s2_valid;
  mask_t               s2_mask;
  mask_t               dec_mask;
  logic                s2_load;
  logic                in_accept;

  // Hold the dialect register
  always_ff @(posedge clk) begin
    if (rst) begin
      dialect <= DIA_STANDARD;
    end else if (cfg_wen) begin
      dialect <= dialect_t'(cfg_wdata);
    end
  end

  // Advance when the result register is empty or being drained
  assign s2_load       = !s2_valid || mask_out.ready;
  assign time_in.ready = !s1_valid || s2_load;
  assign in_accept     = time_in.valid && time_in.ready;

  // Capture the request into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_hours   <= time_in.hours;
      s1_minutes <= time_in.minutes;
    end
  end

  wcws_decode u_decode (
    .hours     (s1_hours),
    .minutes   (s1_minutes),
    .dialect   (dialect),
    .word_mask (dec_mask)
  );

  // Load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      s2_mask <= dec_mask;
    end
  end

  assign mask_out.valid     = s2_valid;
  assign mask_out.word_mask = s2_mask;

`ifndef SYNTHESIS
  // A pending input request moves into the result register when it frees up
  a_s1_to_s2: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_load) |=> s2_valid)
    else $error("input register request not moved to result register");

  // Every result lights ES and IST
  a_es_ist: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (s2_mask[BitEs] && s2_mask[BitIst]))
    else $error("result without ES IST");

  // Exactly one hour word lights
  a_one_hour: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $onehot(s2_mask[BitZwoelf:BitEinShort]))
    else $error("result does not light exactly one hour word");

  // UHR appears only at the full hour, with no minute or relation words
  a_uhr_alone: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_mask[BitUhr]) |->
      ((s2_mask[BitDviertel:BitMFuenf] == '0) && (s2_mask[BitNach:BitVor] == '0)))
    else $error("UHR lit together with minute words");

  // The short EIN only comes with UHR
  a_ein_uhr: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_mask[BitEinShort]) |-> s2_mask[BitUhr])
    else $error("short EIN lit without UHR");

  // Reset empties both stages
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!s1_valid && !s2_valid))
    else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
